>>> rtl/angsec_pkg.sv
// ----------------------------------------------------------------------------
// angsec_pkg
// Shared types and constants for the angle sector commutation sequencer.
// ----------------------------------------------------------------------------
package angsec_pkg;

    // number of commutation sectors per electrical turn
    localparam int SECTOR_COUNT = 6;
    localparam int SECTOR_W     = 3;
    localparam logic [SECTOR_W-1:0] LAST_SECTOR = SECTOR_W'(SECTOR_COUNT - 1);

    // field widths
    localparam int ANGLE_W  = 16;
    localparam int CA_W     = 15;
    localparam int OPCODE_W = 2;

    // bounds carry one extra bit: the full turn and offset bounds exceed 16 bits
    localparam int BOUND_W = ANGLE_W + 1;

    // turn fractions, 65536 is one full turn, thirds rounded to nearest
    localparam logic [BOUND_W-1:0] THIRD_TURN     = 17'd21845;
    localparam logic [BOUND_W-1:0] TWO_THIRD_TURN = 17'd43691;
    localparam logic [BOUND_W-1:0] FULL_TURN      = 17'd65536;

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONDUCTION_ANGLE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRING_ENABLE    = 1'd1;

    // request opcodes
    typedef enum logic [OPCODE_W-1:0] {
        OP_TRACK  = 2'd0,
        OP_SYNC   = 2'd1,
        OP_REFIRE = 2'd2
    } opcode_t;

    typedef logic [BOUND_W-1:0] bound_t;

endpackage

>>> rtl/angle_sector_commutation.sv
// ----------------------------------------------------------------------------
// angle_sector_commutation
// Commutation sequencer: steps a three-phase drive through six rotor-angle
// sectors, resynchronises the sector from the angle and issues fire strobes.
// A request passes the input register, then the result register; one
// request per cycle while results are taken, set by the single sector
// register that each request reads and updates. Reset: asynchronous,
// active low; sector 0, not synced, fire, valids and configuration cleared.
// ----------------------------------------------------------------------------
module angle_sector_commutation
    import angsec_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    // configuration write port
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CA_W-1:0]        cfg_data,

    // request channel
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [OPCODE_W-1:0]    opcode,
    input  logic [ANGLE_W-1:0]     rotor_angle,

    // result channel
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SECTOR_W-1:0]    sector,
    output logic                   fire,
    output logic                   synced
);

    // configuration registers
    logic [CA_W-1:0]     ca_reg;
    logic                fire_en_reg;

    // input stage
    logic                in_valid_reg;
    logic [OPCODE_W-1:0] opcode_reg;
    logic [ANGLE_W-1:0]  angle_reg;

    // state, which doubles as the result register for sector and synced
    logic [SECTOR_W-1:0] sector_reg;
    logic [SECTOR_W-1:0] sector_next;
    logic                synced_reg;
    logic                synced_next;
    logic                fire_reg;
    logic                fire_next;
    logic                out_valid_reg;

    logic                out_free;
    logic                advance;

    bound_t              bounds [0:SECTOR_COUNT];
    bound_t              angle_ext;
    logic [SECTOR_W-1:0] track_sector;
    logic [SECTOR_W-1:0] track_upper;
    logic [SECTOR_W-1:0] sync_sector;
    logic                track_hit;

    // handshake: the result register frees when taken, the input stage
    // moves on whenever the result register is free
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || out_free;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ca_reg      <= '0;
            fire_en_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_CONDUCTION_ANGLE: ca_reg      <= cfg_data;
                CFG_FIRING_ENABLE:    fire_en_reg <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            opcode_reg <= opcode;
            angle_reg  <= rotor_angle;
        end
    end

    // sector bounds
    always_comb
    begin
        bounds[0] = '0;
        bounds[1] = BOUND_W'(ca_reg);
        bounds[2] = THIRD_TURN;
        bounds[3] = THIRD_TURN + BOUND_W'(ca_reg);
        bounds[4] = TWO_THIRD_TURN;
        bounds[5] = TWO_THIRD_TURN + BOUND_W'(ca_reg);
        bounds[6] = FULL_TURN;
    end

    assign angle_ext = BOUND_W'(angle_reg);

    // track: next sector with wrap, both bounds inclusive
    assign track_sector = (sector_reg == LAST_SECTOR) ? '0 : sector_reg + SECTOR_W'(1);
    assign track_upper  = track_sector + SECTOR_W'(1);
    assign track_hit    = (angle_ext >= bounds[track_sector]) &&
                          (angle_ext <= bounds[track_upper]);

    // sync: lowest half-open sector holding the angle, else sector 0
    always_comb
    begin
        sync_sector = '0;
        for (int k = SECTOR_COUNT - 1; k >= 0; k--)
        begin
            if (angle_ext >= bounds[k] && angle_ext < bounds[k + 1])
            begin
                sync_sector = SECTOR_W'(k);
            end
        end
    end

    // next state and fire strobe for the request in the input register
    always_comb
    begin
        sector_next = sector_reg;
        synced_next = synced_reg;
        fire_next   = 1'b0;
        case (opcode_t'(opcode_reg))
            OP_TRACK:
            begin
                if (synced_reg && track_hit)
                begin
                    sector_next = track_sector;
                    fire_next   = fire_en_reg;
                end
            end
            OP_SYNC:
            begin
                sector_next = sync_sector;
                synced_next = 1'b1;
            end
            OP_REFIRE:
            begin
                fire_next = synced_reg && fire_en_reg;
            end
            default: ;
        endcase
    end

    // state and result register, loaded together as the request advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sector_reg    <= '0;
            synced_reg    <= 1'b0;
            fire_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance;
            if (advance)
            begin
                sector_reg <= sector_next;
                synced_reg <= synced_next;
                fire_reg   <= fire_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign sector    = sector_reg;
    assign synced    = synced_reg;
    assign fire      = fire_reg;

endmodule

>>> rtl/angsec_checker.sv
// ----------------------------------------------------------------------------
// angsec_checker
// Port-level checks for the angle sector commutation sequencer.
// ----------------------------------------------------------------------------
module angsec_checker
    import angsec_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [SECTOR_W-1:0] sector,
    input  logic                fire,
    input  logic                synced
);

    logic seen_synced_reg;

    // remember a delivered synced result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_synced_reg <= 1'b0;
        end
        else if (out_valid && out_ready && synced)
        begin
            seen_synced_reg <= 1'b1;
        end
    end

    // sector stays inside the six valid codes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sector <= LAST_SECTOR))
        else $error("sector out of range");

    // a fire strobe only after synchronisation
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && fire) |-> synced)
        else $error("fire before sync");

    // synced never drops once delivered
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && seen_synced_reg) |-> synced)
        else $error("synced flag lost");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(sector) && $stable(fire) && $stable(synced)))
        else $error("stalled result changed");

endmodule

bind angle_sector_commutation angsec_checker u_angsec_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sector    (sector),
    .fire      (fire),
    .synced    (synced)
);

>>> tb/tb_angle_sector_commutation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_angle_sector_commutation
// Self-checking bench for the commutation sequencer. A short directed table
// covers reset behaviour, bound extremes, every opcode, disabled firing and
// oversized conduction angles. Random phases then follow under several
// settings and idling patterns, and every result is checked against a typed
// expectation or an internal sector predictor.
// ----------------------------------------------------------------------------
module tb_angle_sector_commutation;
    import angsec_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 7;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_COUNT    = 9;
    localparam int PHASE_REQUESTS = 187;

    // opcode value outside the defined set, must be ignored by the block
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic                fire;
        logic                synced;
    } commutation_t;

    typedef enum logic {
        ROW_CONFIG,
        ROW_REQUEST
    } row_kind_t;

    typedef struct packed {
        row_kind_t           kind;
        logic [CA_W-1:0]     ca;
        logic                fire_en;
        logic [OPCODE_W-1:0] op;
        logic [ANGLE_W-1:0]  angle;
        logic                typed;
        commutation_t        want;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_CONDUCTION_ANGLE;
    logic [CA_W-1:0]        cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [OPCODE_W-1:0]    opcode = OP_TRACK;
    logic [ANGLE_W-1:0]     rotor_angle = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [SECTOR_W-1:0]    sector;
    logic                   fire;
    logic                   synced;

    // predictor state and its copy of the registers
    logic [SECTOR_W-1:0] track_sector = '0;
    logic                track_synced = 1'b0;
    logic [CA_W-1:0]     cur_ca = '0;
    logic                cur_fire_en = 1'b0;

    commutation_t expected_commutations[$];
    int           mismatch_count = 0;
    int           stall_cycles = 0;
    int           send_idle_pct = 16;
    int           recv_idle_pct = 65;

    // directed table: typed expectations only where obvious
    stim_row_t directed_rows [28] = '{
        '{ROW_REQUEST, 15'd0, 1'b0, OP_TRACK, 16'd0, 1'b1, '{3'd0, 1'b0, 1'b0}},
        '{ROW_REQUEST, 15'd0, 1'b0, OP_REFIRE, 16'd65535, 1'b1, '{3'd0, 1'b0, 1'b0}},
        '{ROW_REQUEST, 15'd0, 1'b0, OP_UNUSED, 16'hAAAA, 1'b1, '{3'd0, 1'b0, 1'b0}},
        '{ROW_CONFIG, 15'd21845, 1'b1, OP_TRACK, 16'd0, 1'b0, '0},
        '{ROW_REQUEST, 15'd0, 1'b0, OP_SYNC, 16'd0, 1'b1, '{3'd0, 1'b0, 1'b1}},
        '{ROW_REQUEST, 15'd0, 1'b0, OP_SYNC, 16'd65535, 1'b1, '{3'd4, 1'b0, 1'b1}},
        '{ROW_REQUEST, 15'd0, 1'b0, OP_TRACK, 16'd0, 1'b0, '0},
        '{ROW_REQUEST, 15'd0, 1'b0, OP_TRACK, 16'd21845, 1'b0, '0},
        '{ROW_REQUEST, 15'd0, 1'b0, OP_TRACK, 16'd21845, 1'b0, '0},
        '{ROW_REQUEST, 15'd0, 1'b0, OP_TRACK, 16'd65535, 1'b0, '0},
        '{ROW_REQUEST, 15'd0, 1'b0, OP_TRACK, 16'd43691, 1'b0, '0},
        '{ROW_REQUEST, 15'd0, 1'b0, OP_REFIRE, 16'd0, 1'b0, '0},
        '{ROW_REQUEST, 15'd0, 1'b0, OP_UNUSED, 16'hFFFF, 1'b0, '0},
        '{ROW_CONFIG, 15'd21845, 1'b0, OP_TRACK, 16'd0, 1'b0, '0},
        '{ROW_REQUEST, 15'd0, 1'b0, OP_TRACK, 16'd43691, 1'b0, '0},
        '{ROW_REQUEST, 15'd0, 1'b0, OP_REFIRE, 16'd0, 1'b0, '0},
        '{ROW_CONFIG, 15'd0, 1'b1, OP_TRACK, 16'd0, 1'b0, '0},
        '{ROW_REQUEST, 15'd0, 1'b0, OP_SYNC, 16'd0, 1'b0, '0},
        '{ROW_REQUEST, 15'd0, 1'b0, OP_SYNC, 16'd21845, 1'b0, '0},
        '{ROW_REQUEST, 15'd0, 1'b0, OP_SYNC, 16'd65535, 1'b0, '0},
        '{ROW_REQUEST, 15'd0, 1'b0, OP_TRACK, 16'd0, 1'b0, '0},
        '{ROW_CONFIG, 15'd32767, 1'b1, OP_TRACK, 16'd0, 1'b0, '0},
        '{ROW_REQUEST, 15'd0, 1'b0, OP_SYNC, 16'd30000, 1'b0, '0},
        '{ROW_REQUEST, 15'd0, 1'b0, OP_SYNC, 16'd40000, 1'b0, '0},
        '{ROW_REQUEST, 15'd0, 1'b0, OP_SYNC, 16'd60000, 1'b0, '0},
        '{ROW_REQUEST, 15'd0, 1'b0, OP_TRACK, 16'd60000, 1'b0, '0},
        '{ROW_REQUEST, 15'd0, 1'b0, OP_SYNC, 16'd32767, 1'b0, '0},
        '{ROW_REQUEST, 15'd0, 1'b0, OP_TRACK, 16'd54612, 1'b0, '0}
    };

    angle_sector_commutation u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .rotor_angle  (rotor_angle),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sector       (sector),
        .fire         (fire),
        .synced       (synced)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #CLK_HALF;
        clk = 1'b0;
        #CLK_HALF;
    end

    // lower bound of sector k, k = 6 is the full turn; no wrap on offsets
    function automatic bound_t sector_bound(input int k);
        case (k)
            0:       return '0;
            1:       return bound_t'(cur_ca);
            2:       return THIRD_TURN;
            3:       return THIRD_TURN + bound_t'(cur_ca);
            4:       return TWO_THIRD_TURN;
            5:       return TWO_THIRD_TURN + bound_t'(cur_ca);
            default: return FULL_TURN;
        endcase
    endfunction

    function automatic logic [SECTOR_W-1:0] next_sector(input logic [SECTOR_W-1:0] cur);
        return (cur >= LAST_SECTOR) ? '0 : cur + SECTOR_W'(1);
    endfunction

    // sector sequencing, updates the predictor state
    function automatic commutation_t predict_commutation(input logic [OPCODE_W-1:0] op,
                                                         input logic [ANGLE_W-1:0] angle);
        commutation_t        res;
        logic [SECTOR_W-1:0] nxt;
        bound_t              a;
        logic                found;
        a = bound_t'(angle);
        res.fire = 1'b0;
        case (op)
            OP_TRACK:
            begin
                if (track_synced)
                begin
                    nxt = next_sector(track_sector);
                    if (a >= sector_bound(int'(nxt)) && a <= sector_bound(int'(nxt) + 1))
                    begin
                        track_sector = nxt;
                        res.fire = cur_fire_en;
                    end
                end
            end
            OP_SYNC:
            begin
                // lowest half-open range holding the angle, sector 0 if none
                found = 1'b0;
                track_sector = '0;
                for (int k = 0; k < SECTOR_COUNT; k++)
                begin
                    if (!found && a >= sector_bound(k) && a < sector_bound(k + 1))
                    begin
                        found = 1'b1;
                        track_sector = SECTOR_W'(k);
                    end
                end
                track_synced = 1'b1;
            end
            OP_REFIRE:
            begin
                if (track_synced)
                    res.fire = cur_fire_en;
            end
            default:
            begin
                // unused opcode leaves everything alone
            end
        endcase
        res.sector = track_sector;
        res.synced = track_synced;
        return res;
    endfunction

    // one request: idle gaps, then hold valid until accepted
    task automatic issue_request(input logic [OPCODE_W-1:0] op, input logic [ANGLE_W-1:0] angle,
                                 input logic typed, input commutation_t want);
        commutation_t predicted;
        predicted = predict_commutation(op, angle);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        rotor_angle <= angle;
        do
            @(posedge clk);
        while (!in_ready);
        expected_commutations.push_back(typed ? want : predicted);
    endtask

    // both registers, written only once the pipeline has drained
    task automatic write_settings(input logic [CA_W-1:0] ca, input logic fire_en);
        in_valid <= 1'b0;
        while (expected_commutations.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= CFG_CONDUCTION_ANGLE;
        cfg_data     <= ca;
        @(posedge clk);
        cfg_index    <= CFG_FIRING_ENABLE;
        cfg_data     <= CA_W'(fire_en);
        @(posedge clk);
        cfg_write_en <= 1'b0;
        cur_ca      = ca;
        cur_fire_en = fire_en;
    endtask

    function automatic logic [ANGLE_W-1:0] random_angle();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return ANGLE_W'($urandom_range(65535));
        endcase
    endfunction

    // mostly tracking through consecutive sectors, plus syncs, re-fires and noise
    task automatic pick_request(output logic [OPCODE_W-1:0] op,
                                output logic [ANGLE_W-1:0] angle);
        int     roll;
        int     nxt;
        bound_t lo;
        bound_t hi;
        roll = $urandom_range(99);
        angle = random_angle();
        if (!track_synced || roll < 8)
            op = OP_SYNC;
        else if (roll < 63)
        begin
            op  = OP_TRACK;
            nxt = int'(next_sector(track_sector));
            lo  = sector_bound(nxt);
            hi  = sector_bound(nxt + 1);
            if (hi > bound_t'(16'hFFFF))
                hi = bound_t'(16'hFFFF);
            if (lo <= hi)
            begin
                case ($urandom_range(5))
                    0:       angle = ANGLE_W'(lo);
                    1:       angle = ANGLE_W'(hi);
                    default: angle = ANGLE_W'($urandom_range(int'(hi), int'(lo)));
                endcase
            end
        end
        else if (roll < 78)
            op = OP_TRACK;
        else if (roll < 94)
            op = OP_REFIRE;
        else
            op = OP_UNUSED;
    endtask

    // receiver back-pressure
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // result checking and watchdog
    always @(posedge clk)
    begin
        commutation_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_commutations.size() == 0)
                begin
                    mismatch_count++;
                    $error("unexpected result: sector %0d fire %0d synced %0d",
                           sector, fire, synced);
                end
                else
                begin
                    want = expected_commutations.pop_front();
                    if (sector !== want.sector)
                    begin
                        mismatch_count++;
                        $error("sector: expected %0d, actual %0d", want.sector, sector);
                    end
                    if (fire !== want.fire)
                    begin
                        mismatch_count++;
                        $error("fire: expected %0d, actual %0d", want.fire, fire);
                    end
                    if (synced !== want.synced)
                    begin
                        mismatch_count++;
                        $error("synced: expected %0d, actual %0d", want.synced, synced);
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        logic [CA_W-1:0]     ca;
        logic                fire_en;
        logic [OPCODE_W-1:0] op;
        logic [ANGLE_W-1:0]  angle;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CONFIG)
                write_settings(directed_rows[i].ca, directed_rows[i].fire_en);
            else
                issue_request(directed_rows[i].op, directed_rows[i].angle,
                              directed_rows[i].typed, directed_rows[i].want);
        end

        // random phases: idling pattern changes every third phase
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p / 3)
                0:
                begin
                    send_idle_pct = 16;
                    recv_idle_pct = 65;
                end
                1:
                begin
                    send_idle_pct = 65;
                    recv_idle_pct = 16;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (p)
                0:       ca = '0;
                1:       ca = 15'd21845;
                3:       ca = '1;
                5:       ca = 15'd1;
                6:       ca = 15'd21844;
                7:       ca = CA_W'($urandom_range(32767));
                default: ca = CA_W'($urandom_range(21845));
            endcase
            fire_en = (p == 4) ? 1'b0 : (p == 8) ? 1'($urandom_range(1)) : 1'b1;
            write_settings(ca, fire_en);
            repeat (PHASE_REQUESTS)
            begin
                pick_request(op, angle);
                issue_request(op, angle, 1'b0, '0);
            end
        end

        // drain and report
        in_valid <= 1'b0;
        while (expected_commutations.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
